/* design/olt_pkg.sv */
// Shared codes and types for the ordered list table.
// Used by the sequencer and the top level; depends on nothing.
`default_nettype none

package olt_pkg;

  localparam logic [1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [1:0] KIND_INS_BACK  = 2'd1;
  localparam logic [1:0] KIND_DELETE    = 2'd2;
  localparam logic [1:0] KIND_SEARCH    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [POS_W-1:0]   position;
    logic [1:0]         status;
  } result_t;

endpackage

`default_nettype wire

/* design/olt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/olt_seq.sv */
// Sequencer of the ordered list table: walks and shifts the entry RAM one entry a cycle
// with a single compare unit. Depends on olt_pkg.
`default_nettype none

module olt_seq #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [1:0]                  req_kind,
  input  wire logic [31:0]                 req_value,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output olt_pkg::result_t                 res,
  output logic                             ram_we,
  output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
  output logic [31:0]                      ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
  input  wire logic [31:0]                 ram_rdata
);

  import olt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_INSF = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic [AW-1:0] cmp_r, cmp_nxt;
  logic          pend_r, pend_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  logic [CW-1:0]       src_dec;
  logic [AW-1:0]       src_lo;
  logic [AW-1:0]       dec_lo;
  logic                full;
  logic [AW+POS_W-1:0] pos_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign src_dec = src_r - 1'b1;
  assign src_lo  = src_r[AW-1:0];
  assign dec_lo  = src_dec[AW-1:0];
  assign full    = (len_r >= CW'(CAPACITY));
  assign pos_ext = {{POS_W{1'b0}}, pos_r};
  assign cnt_ext = {{COUNT_W{1'b0}}, len_r};

  assign req_ready       = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_RESP);
  assign res.status      = status_r;
  assign res.position    = pos_ext[POS_W-1:0];
  assign res.entry_count = cnt_ext[COUNT_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    cmp_nxt    = cmp_r;
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    ram_we     = 1'b0;
    ram_waddr  = dst_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = src_lo;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt   = req_kind;
          val_nxt    = req_value;
          pend_nxt   = 1'b0;
          pos_nxt    = '0;
          status_nxt = ST_OK;
          case (req_kind)
            KIND_INS_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                src_nxt   = len_r;
                state_nxt = S_INSF;
              end
            end
            KIND_INS_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = len_r[AW-1:0];
                ram_wdata = req_value;
                len_nxt   = len_r + 1'b1;
              end
              state_nxt = S_RESP;
            end
            default: begin
              if (len_r == '0) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                src_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (src_r < len_r) begin
          ram_raddr = src_lo;
          cmp_nxt   = src_lo;
          src_nxt   = src_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (ram_rdata == val_r) begin
            pend_nxt = 1'b0;
            if (kind_r == KIND_SEARCH) begin
              pos_nxt   = cmp_r;
              state_nxt = S_RESP;
            end else begin
              src_nxt   = CW'(cmp_r) + 1'b1;
              state_nxt = S_DEL;
            end
          end else if (CW'(cmp_r) == len_r - 1'b1) begin
            pend_nxt   = 1'b0;
            status_nxt = ST_MISS;
            state_nxt  = S_RESP;
          end
        end
      end
      S_DEL: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (src_r < len_r) begin
          ram_raddr = src_lo;
          dst_nxt   = src_lo - 1'b1;
          src_nxt   = src_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            len_nxt   = len_r - 1'b1;
            state_nxt = S_RESP;
          end
        end
      end
      S_INSF: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (src_r != '0) begin
          ram_raddr = dec_lo;
          dst_nxt   = src_lo;
          src_nxt   = src_dec;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = val_r;
            len_nxt   = len_r + 1'b1;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
    end
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    cmp_r    <= cmp_nxt;
    kind_r   <= kind_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

endmodule

`default_nettype wire

/* design/ordered_list_table.sv */
// Top level of the ordered list table: stream ports, result register and entry RAM.
// Depends on olt_pkg, olt_seq and olt_ram.
`default_nettype none

// An ordered list of up to CAPACITY signed 32-bit values, empty after reset. Each input
// word carries an operation in in_tuser and a value in in_tdata; each one gives exactly one
// result word. The block takes one request at a time. Insert at back writes the value
// straight into the entry RAM; insert at front first moves every entry one place back;
// search and delete walk the entry RAM from the head, one entry a cycle, a rate set by the
// single read and write port of that RAM. The result waits in an output register, so the
// next request can be taken while the previous result is still held.
module ordered_list_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // status[1:0], position[7:2], entry_count[14:8]
);

  import olt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          out_valid_r;
  result_t       out_word_r;

  olt_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_value (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  olt_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_word_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_word_r <= res;
    end
  end

endmodule

`default_nettype wire

/* dv/ordered_list_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_table: directed and random list requests on the input stream.
// Keeps its own copy of the list, predicts each result word and compares it field by field.
// Depends on olt_pkg and the ordered_list_table RTL only.

module ordered_list_table_tb;
  import olt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = KIND_SEARCH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic [31:0]  shadow_list[$];
  result_t      pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           sender_quiet = 1'b0;
  bit           sink_quiet = 1'b0;
  bit           hold_request = 1'b0;

  ordered_list_table #(.CAPACITY(CAPACITY)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one request to the shadow list and returns the result word it should give.
  function automatic result_t apply_list_op(logic [1:0] kind, logic [31:0] value);
    result_t res;
    int      hit;
    res.status = ST_OK;
    res.position = '0;
    hit = -1;
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (hit < 0 && shadow_list[i] == value) hit = i;
    end
    case (kind)
      KIND_INS_FRONT: begin
        if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
        else shadow_list.push_front(value);
      end
      KIND_INS_BACK: begin
        if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
        else shadow_list.push_back(value);
      end
      KIND_DELETE: begin
        if (hit < 0) res.status = ST_MISS;
        else shadow_list.delete(hit);
      end
      default: begin
        if (hit < 0) res.status = ST_MISS;
        else res.position = POS_W'(hit);
      end
    endcase
    res.entry_count = COUNT_W'(shadow_list.size());
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycle_count, got,
             want);
    mismatch_count++;
  endtask

  // Offers one request word and waits until the block takes it.
  task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
    int unsigned gap;
    gap = pick_gap(sender_quiet);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_op(kind, value));
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[14:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_tdata), -1);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.position != want.position)
          report_mismatch("position", got.position, want.position);
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (out_tdata[15] !== 1'b0)
          report_mismatch("padding bit", out_tdata[15], 0);
      end
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned burst;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        hold_left = LONG_HOLD;
        while (hold_left != 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        out_tready <= 1'b1;
        burst = sink_quiet ? 16 : $urandom_range(1, 8);
        repeat (burst) @(posedge clk);
        hold_left = pick_gap(sink_quiet);
        if (hold_left != 0) begin
          out_tready <= 1'b0;
          repeat (hold_left) @(posedge clk);
        end
      end
    end
  end

  // Half of the values come from the list so that deletes and searches mostly hit.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 7)
      return ($urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h0) | 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic test_empty_list();
    sender_quiet = 1'b1;
    sink_quiet = 1'b1;
    send_request(KIND_DELETE, 32'h8000_0000);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h0000_0000);
  endtask

  task automatic test_basic_ops();
    send_request(KIND_INS_FRONT, 32'h7FFF_FFFF);
    send_request(KIND_INS_BACK, 32'h8000_0000);
    send_request(KIND_INS_BACK, 32'h0000_0000);
    send_request(KIND_INS_FRONT, 32'hFFFF_FFFF);
    send_request(KIND_INS_BACK, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h8000_0000);
    send_request(KIND_SEARCH, 32'h1234_5678);
    send_request(KIND_DELETE, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_DELETE, 32'h1234_5678);
    send_request(KIND_DELETE, 32'hFFFF_FFFF);
    send_request(KIND_DELETE, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h0000_0000);
    send_request(KIND_DELETE, 32'h8000_0000);
    send_request(KIND_DELETE, 32'h0000_0000);
    send_request(KIND_SEARCH, 32'h0000_0000);
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY - 1)
      send_request($urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_BACK, $urandom);
    send_request(KIND_INS_BACK, 32'hA5A5_0F0F);
    send_request(KIND_INS_FRONT, 32'h7FFF_FFFF);
    send_request(KIND_INS_BACK, 32'h8000_0000);
    send_request(KIND_SEARCH, 32'hA5A5_0F0F);
    send_request(KIND_SEARCH, shadow_list[0]);
    send_request(KIND_DELETE, 32'hA5A5_0F0F);
    send_request(KIND_INS_BACK, 32'hA5A5_0F0F);
    send_request(KIND_DELETE, shadow_list[0]);
    while (shadow_list.size() > 0) begin
      if ($urandom_range(0, 9) == 0) send_request(KIND_DELETE, $urandom);
      else send_request(KIND_DELETE, shadow_list[$urandom_range(0, shadow_list.size() - 1)]);
    end
  endtask

  task automatic test_backpressure();
    sender_quiet = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_request(2'($urandom_range(0, 3)), pick_value());
    sender_quiet = 1'b0;
  endtask

  // Picks growing or shrinking phases at random, turning to shrink when the list is full and to grow when it is empty.
  task automatic test_random_mix(input int unsigned count);
    bit          growing;
    int unsigned r;
    logic [1:0]  kind;
    growing = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) growing = $urandom_range(0, 1);
      if (shadow_list.size() >= CAPACITY) growing = 1'b0;
      if (shadow_list.size() == 0) growing = 1'b1;
      if (n % 150 == 0) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (growing)
        kind = (r < 35) ? KIND_INS_FRONT : (r < 70) ? KIND_INS_BACK :
               (r < 85) ? KIND_DELETE : KIND_SEARCH;
      else
        kind = (r < 15) ? KIND_INS_FRONT : (r < 30) ? KIND_INS_BACK :
               (r < 70) ? KIND_DELETE : KIND_SEARCH;
      send_request(kind, pick_value());
    end
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_backpressure();
    test_random_mix(620);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
